[rtl/grid_line_rasterizer_top_assert.svh]
// ----------------------------------------------------------------------------
// grid line rasteriser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_RASTERIZER_TOP_ASSERT_SVH
`define GRID_LINE_RASTERIZER_TOP_ASSERT_SVH

// next-cycle implication, ignored while reset is low
`define GLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define GLR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/glr_pkg.sv]
// ----------------------------------------------------------------------------
// glr_pkg
// types shared by the grid line rasteriser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glr_pkg;

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int INDEX_W = 12;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [INDEX_W-1:0] index_t;

  // one traced cell as it leaves the block
  typedef struct packed {
    coord_t cell_x;
    coord_t cell_y;
    index_t cell_index;
    logic   in_map;
    logic   is_last;
  } glr_cell_t;

  // register indexes on the configuration port
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } glr_reg_t;

endpackage

[rtl/glr_cell_unit.sv]
// ----------------------------------------------------------------------------
// glr_cell_unit
// forms one result: linear index and map bounds check for a traced cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glr_cell_unit
  import glr_pkg::*;
(
  input  coord_t    cx,
  input  coord_t    cy,
  input  logic      last,
  input  logic      degen,
  input  dim_t      grid_width,
  input  dim_t      grid_height,
  output glr_cell_t traced
);

  logic [COORD_W+DIM_W-1:0] prod;
  logic [COORD_W+DIM_W:0]   sum;
  logic                     in_bounds;

  assign prod      = cy * grid_width;
  assign sum       = {{(DIM_W+1){1'b0}}, cx} + {1'b0, prod};
  assign in_bounds = ({1'b0, cx} < grid_width) && ({1'b0, cy} < grid_height);

  always_comb begin
    traced.cell_x     = cx;
    traced.cell_y     = cy;
    traced.cell_index = sum[INDEX_W-1:0];
    traced.in_map     = in_bounds;
    traced.is_last    = last;
    // a single-point segment reports index zero and no map hit
    if (degen) begin
      traced.cell_index = '0;
      traced.in_map     = 1'b0;
      traced.is_last    = 1'b1;
    end
  end

endmodule

[rtl/grid_line_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// grid_line_rasterizer_top
// traces a grid segment with integer Bresenham, one cell per result
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  start_x start_y end_x end_y
//  out_     output     out_valid/out_stall cell_x cell_y cell_index in_map is_last
//  cfg_     input      cfg_valid/cfg_ready cfg_index cfg_data
//
//  a segment of n cells is set up in IDLE, then the walk stepper emits one
//  cell per cycle while out_stall allows it (n is 1 to GRID_DIM - 1)
//  in_stall stays high from the accepted request until the last cell enters
//  the output register; out_stall holds the stepper in place
//  reset is synchronous and restores width and height to GRID_DIM
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_line_rasterizer_top
  import glr_pkg::*;
#(
  parameter int GRID_DIM = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t out_cell_x,
  output coord_t out_cell_y,
  output index_t out_cell_index,
  output logic   out_in_map,
  output logic   out_is_last,
  input  logic   cfg_valid,
  output logic   cfg_ready,
  input  logic   cfg_index,
  input  dim_t   cfg_data
);

  localparam int CNT_W = $clog2(GRID_DIM);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GRID_DIM - 2);

  typedef enum logic {
    IDLE,
    WALK
  } state_t;

  state_t      state_r, state_nxt;
  dim_t        width_r, width_nxt;
  dim_t        height_r, height_nxt;
  coord_t      major_pos_r, major_pos_nxt;
  coord_t      minor_pos_r, minor_pos_nxt;
  coord_t      major_end_r, major_end_nxt;
  coord_t      major_delta_r, major_delta_nxt;
  coord_t      minor_delta_r, minor_delta_nxt;
  logic signed [7:0] err_r, err_nxt;
  logic        steep_r, steep_nxt;
  logic        down_r, down_nxt;
  logic        degen_r, degen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  glr_cell_t   out_r, out_nxt;

  // setup of the walk
  coord_t adx, ady, a0, b0, a1, b1;
  logic   steep;

  // stepper
  logic signed [8:0] err_sum;
  logic              minor_step;
  logic              last;
  logic              load;
  coord_t            cx, cy;
  glr_cell_t         traced;

  assign in_stall  = (state_r != IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    adx   = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
    ady   = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
    steep = ady > adx;
    a0 = steep ? in_start_y : in_start_x;
    b0 = steep ? in_start_x : in_start_y;
    a1 = steep ? in_end_y : in_end_x;
    b1 = steep ? in_end_x : in_end_y;
    // walk up the major axis
    if (a0 > a1) begin
      a0 = steep ? in_end_y : in_end_x;
      b0 = steep ? in_end_x : in_end_y;
      a1 = steep ? in_start_y : in_start_x;
      b1 = steep ? in_start_x : in_start_y;
    end
  end

  assign cx   = steep_r ? minor_pos_r : major_pos_r;
  assign cy   = steep_r ? major_pos_r : minor_pos_r;
  assign last = (major_pos_r + 6'd1 == major_end_r) || (cnt_r == LAST_CNT);
  assign load = (state_r == WALK) && (!out_valid_r || !out_stall);

  assign err_sum    = 9'(err_r) + $signed({3'b000, minor_delta_r});
  // minor axis steps when twice the error reaches the major extent
  assign minor_step = $signed({err_sum[7:0], 1'b0}) >= $signed({3'b000, major_delta_r});

  glr_cell_unit u_cell (
    .cx          (cx),
    .cy          (cy),
    .last        (last),
    .degen       (degen_r),
    .grid_width  (width_r),
    .grid_height (height_r),
    .traced      (traced)
  );

  always_comb begin
    state_nxt       = state_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    major_end_nxt   = major_end_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    err_nxt         = err_r;
    steep_nxt       = steep_r;
    down_nxt        = down_r;
    degen_nxt       = degen_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;

    if (cfg_valid && cfg_ready) begin
      case (glr_reg_t'(cfg_index))
        REG_GRID_WIDTH:  width_nxt  = cfg_data;
        REG_GRID_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      IDLE: begin
        if (in_valid) begin
          major_pos_nxt   = a0;
          minor_pos_nxt   = b0;
          major_end_nxt   = a1;
          major_delta_nxt = a1 - a0;
          minor_delta_nxt = (b1 >= b0) ? b1 - b0 : b0 - b1;
          down_nxt        = !(b0 < b1);
          steep_nxt       = steep;
          degen_nxt       = (a1 == a0);
          err_nxt         = '0;
          cnt_nxt         = '0;
          state_nxt       = WALK;
        end
      end
      WALK: begin
        if (load) begin
          out_nxt       = traced;
          out_valid_nxt = 1'b1;
          if (degen_r || last) begin
            state_nxt = IDLE;
          end else begin
            cnt_nxt       = cnt_r + 1'b1;
            major_pos_nxt = major_pos_r + 6'd1;
            if (minor_step) begin
              minor_pos_nxt = down_r ? minor_pos_r - 6'd1 : minor_pos_r + 6'd1;
              err_nxt       = err_sum[7:0] - $signed({2'b00, major_delta_r});
            end else begin
              err_nxt = err_sum[7:0];
            end
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= IDLE;
      width_r       <= DIM_W'(GRID_DIM);
      height_r      <= DIM_W'(GRID_DIM);
      major_pos_r   <= '0;
      minor_pos_r   <= '0;
      major_end_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      err_r         <= '0;
      steep_r       <= 1'b0;
      down_r        <= 1'b0;
      degen_r       <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      major_pos_r   <= major_pos_nxt;
      minor_pos_r   <= minor_pos_nxt;
      major_end_r   <= major_end_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      err_r         <= err_nxt;
      steep_r       <= steep_nxt;
      down_r        <= down_nxt;
      degen_r       <= degen_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_r.cell_x;
  assign out_cell_y     = out_r.cell_y;
  assign out_cell_index = out_r.cell_index;
  assign out_in_map     = out_r.in_map;
  assign out_is_last    = out_r.is_last;

endmodule

[rtl/glr_checker.sv]
// ----------------------------------------------------------------------------
// glr_checker
// port-level checks for the grid line rasteriser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_line_rasterizer_top_assert.svh"

module glr_checker
  import glr_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input coord_t out_cell_x,
  input coord_t out_cell_y,
  input index_t out_cell_index,
  input logic   out_in_map,
  input logic   out_is_last
);

  logic      held;
  glr_cell_t payload;

  assign held    = out_valid && out_stall;
  assign payload = {out_cell_x, out_cell_y, out_cell_index, out_in_map, out_is_last};

  // a stalled result keeps its payload
  `GLR_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(payload), "stalled result moved")

  // an accepted request blocks the input while its cells are traced
  `GLR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "input open after request")

  // reset leaves no result pending and the input open
  `GLR_ASSERT_ALWAYS(a_reset_clean, !rst_n, !out_valid && !in_stall, "state not cleared by reset")

endmodule

bind grid_line_rasterizer_top glr_checker u_glr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_x     (out_cell_x),
  .out_cell_y     (out_cell_y),
  .out_cell_index (out_cell_index),
  .out_in_map     (out_in_map),
  .out_is_last    (out_is_last)
);
